@@ sv/stm_pkg.sv @@
// Shared types and constants of the spatiotemporal median block.
package stm_pkg;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_FRAME_COUNT  = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_DRAIN,
        ST_SELECT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       command;
        logic [1:0] frame_index;
        logic [5:0] x_pos;
        logic [5:0] y_pos;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_median;
        logic [7:0] green_median;
        logic [7:0] blue_median;
        logic [6:0] sample_count;
        logic       coord_error;
    } out_item_t;

    // channel 2 red, 1 green, 0 blue
    typedef logic [2:0][7:0] pixel_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } chain_ctl_t;

endpackage

@@ sv/spatiotemporal_median_top.sv @@
// Top level of the spatiotemporal median filter: frame store, sequencer, sorting chain.
//
// Usage:
//  - Command channel: item is taken at a rising edge with start high and busy low.
//    A load (command 0) writes one pixel into the frame store in that same edge and
//    gives no result; busy stays low, so loads may follow every cycle.
//  - A query (command 1) raises busy. The sequencer walks the window rows, columns
//    and frames, one frame store read per step (single read port), and each read
//    sample is inserted into a chain of sorting cells in the following cycle.
//  - The chain is then shifted toward cell 0 count/2 times; cell 0 holds the
//    upper median of each channel.
//  - A query passes through the gather, drain, select and result states in that
//    order; a query outside the image goes straight to the result state.
//  - Result: done is high for exactly one cycle with result valid; the transfer
//    completes at the edge ending that cycle. The receiver cannot stall.
//  - Configuration: APB write of four registers at byte addresses 0, 4, 8, 12.
//    Write only while busy is low.
//  - Reset: registers return to 3, 1, 64, 64; sequencer idle; frame store is not
//    cleared and must be loaded before it is queried.
module spatiotemporal_median_top
    import stm_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_FRAMES = 4,
    parameter int MAX_WINDOW = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_item_t    item,
    output logic        busy,
    output logic        done,
    output out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_FRAMES * MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NCELL = MAX_WINDOW * MAX_WINDOW * MAX_FRAMES;
    localparam int NW    = $clog2(NCELL + 1);
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int FW    = $clog2(MAX_FRAMES + 1);
    localparam int CW    = 14;   // coordinate arithmetic, covers 4096 + window

    // ---------------- configuration registers ----------------
    logic [2:0] window_size_reg, frame_count_reg;
    logic [6:0] image_width_reg, image_height_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= 3'd3;
            frame_count_reg  <= 3'd1;
            image_width_reg  <= 7'd64;
            image_height_reg <= 7'd64;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_WINDOW_SIZE:  window_size_reg  <= pwdata[2:0];
                REG_FRAME_COUNT:  frame_count_reg  <= pwdata[2:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[6:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_WINDOW_SIZE:  prdata = {29'd0, window_size_reg};
            REG_FRAME_COUNT:  prdata = {29'd0, frame_count_reg};
            REG_IMAGE_WIDTH:  prdata = {25'd0, image_width_reg};
            REG_IMAGE_HEIGHT: prdata = {25'd0, image_height_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // effective (saturated) settings
    logic [WW-1:0] ws;
    logic [FW-1:0] fc;
    logic [CW-1:0] w_eff, h_eff, half;

    always_comb
    begin
        if (window_size_reg == 3'd0)
            ws = WW'(1);
        else if (int'(window_size_reg) > MAX_WINDOW)
            ws = WW'(MAX_WINDOW);
        else
            ws = WW'(window_size_reg);
        if (frame_count_reg == 3'd0)
            fc = FW'(1);
        else if (int'(frame_count_reg) > MAX_FRAMES)
            fc = FW'(MAX_FRAMES);
        else
            fc = FW'(frame_count_reg);
        w_eff = (int'(image_width_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(image_width_reg);
        h_eff = (int'(image_height_reg) > MAX_HEIGHT) ? CW'(MAX_HEIGHT)
                                                       : CW'(image_height_reg);
        half  = CW'(ws >> 1);
    end

    // ---------------- sequencer ----------------
    state_t        state_reg, state_next;
    logic [WW-1:0] wy_reg, wy_next, wx_reg, wx_next;
    logic [FW-1:0] f_reg, f_next;
    logic [NW-1:0] n_reg, n_next, k_reg, k_next;
    logic [5:0]    qx_reg, qy_reg;
    logic          err_reg, err_next;
    logic          rd_v_reg;

    logic accept, acc_load, acc_query, q_outside, step_last;
    logic [CW-1:0] sy_sum, sx_sum, sy, sx;
    logic          in_y, in_x, rd_v;
    logic [31:0]   raddr_full, waddr_full;
    chain_ctl_t    ctl;

    assign accept    = start && !busy;
    assign acc_load  = accept && (cmd_t'(item.command) == CMD_LOAD);
    assign acc_query = accept && (cmd_t'(item.command) == CMD_QUERY);
    assign q_outside = (CW'(item.x_pos) >= w_eff) || (CW'(item.y_pos) >= h_eff);
    assign step_last = (f_reg == fc - FW'(1)) && (wx_reg == ws - WW'(1))
                     && (wy_reg == ws - WW'(1));

    // window sample position and bounds
    assign sy_sum = CW'(qy_reg) + CW'(wy_reg);
    assign sx_sum = CW'(qx_reg) + CW'(wx_reg);
    assign sy     = sy_sum - half;
    assign sx     = sx_sum - half;
    assign in_y   = (sy_sum >= half) && (sy < h_eff);
    assign in_x   = (sx_sum >= half) && (sx < w_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc_query)
                    state_next = q_outside ? ST_DONE : ST_GATHER;
            end
            ST_GATHER:
            begin
                if (step_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_SELECT;
            ST_SELECT:
            begin
                if (k_reg == (n_reg >> 1))
                    state_next = ST_DONE;
            end
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        busy       = 1'b1;
        done       = 1'b0;
        rd_v       = 1'b0;
        ctl        = '0;
        wy_next    = wy_reg;
        wx_next    = wx_reg;
        f_next     = f_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        n_next     = n_reg;
        if (rd_v_reg)
            n_next = n_reg + NW'(1);
        ctl.insert = rd_v_reg;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (acc_query)
                begin
                    ctl.clear = 1'b1;
                    n_next    = '0;
                    wy_next   = '0;
                    wx_next   = '0;
                    f_next    = '0;
                    k_next    = '0;
                    err_next  = q_outside;
                end
            end
            ST_GATHER:
            begin
                rd_v = in_x && in_y;
                if (f_reg == fc - FW'(1))
                begin
                    f_next = '0;
                    if (wx_reg == ws - WW'(1))
                    begin
                        wx_next = '0;
                        wy_next = wy_reg + WW'(1);
                    end
                    else
                        wx_next = wx_reg + WW'(1);
                end
                else
                    f_next = f_reg + FW'(1);
            end
            ST_DRAIN: ;
            ST_SELECT:
            begin
                if (k_reg != (n_reg >> 1))
                begin
                    ctl.shift = 1'b1;
                    k_next    = k_reg + NW'(1);
                end
            end
            ST_DONE:   done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_v_reg  <= 1'b0;
            n_reg     <= '0;
            k_reg     <= '0;
            wy_reg    <= '0;
            wx_reg    <= '0;
            f_reg     <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= rd_v;
            n_reg     <= n_next;
            k_reg     <= k_next;
            wy_reg    <= wy_next;
            wx_reg    <= wx_next;
            f_reg     <= f_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_query)
        begin
            qx_reg <= item.x_pos;
            qy_reg <= item.y_pos;
        end
    end

    // ---------------- frame store ----------------
    logic [23:0]   mem [DEPTH];
    logic [23:0]   rdata_reg;
    logic          wr_en;
    logic [AW-1:0] waddr, raddr;

    assign wr_en = acc_load && (int'(item.frame_index) < MAX_FRAMES)
                 && (int'(item.x_pos) < MAX_WIDTH) && (int'(item.y_pos) < MAX_HEIGHT);
    assign waddr_full = 32'(item.frame_index) * 32'(MAX_HEIGHT * MAX_WIDTH)
                      + 32'(item.y_pos) * 32'(MAX_WIDTH) + 32'(item.x_pos);
    assign raddr_full = 32'(f_reg) * 32'(MAX_HEIGHT * MAX_WIDTH)
                      + 32'(sy) * 32'(MAX_WIDTH) + 32'(sx);
    assign waddr = waddr_full[AW-1:0];
    assign raddr = raddr_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= {item.red_in, item.green_in, item.blue_in};
        rdata_reg <= mem[raddr];
    end

    // ---------------- sorting chain ----------------
    pixel_t     din;
    pixel_t     cval   [NCELL];
    logic       cvalid [NCELL];
    logic [2:0] cgt    [NCELL];

    assign din = rdata_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        pixel_t     pv, nv;
        logic       pvld, nvld;
        logic [2:0] pgt;
        if (i == 0)
        begin : g_first
            assign pv   = '0;
            assign pvld = 1'b1;
            assign pgt  = 3'b000;
        end
        else
        begin : g_mid
            assign pv   = cval[i-1];
            assign pvld = cvalid[i-1];
            assign pgt  = cgt[i-1];
        end
        if (i == NCELL - 1)
        begin : g_last
            assign nv   = '0;
            assign nvld = 1'b0;
        end
        else
        begin : g_inner
            assign nv   = cval[i+1];
            assign nvld = cvalid[i+1];
        end
        stm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .din        (din),
            .prev_val   (pv),
            .prev_valid (pvld),
            .prev_gt    (pgt),
            .next_val   (nv),
            .next_valid (nvld),
            .val        (cval[i]),
            .valid      (cvalid[i]),
            .gt         (cgt[i])
        );
    end

    // ---------------- result ----------------
    always_comb
    begin
        if (err_reg)
        begin
            result             = '0;
            result.coord_error = 1'b1;
        end
        else
        begin
            result.red_median   = cval[0][2];
            result.green_median = cval[0][1];
            result.blue_median  = cval[0][0];
            result.sample_count = 7'(n_reg);
            result.coord_error  = 1'b0;
        end
    end

endmodule

@@ sv/stm_cell.sv @@
// One cell of the insertion sorting chain, three independent channels.
module stm_cell
    import stm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_ctl_t ctl,
    input  pixel_t     din,
    input  pixel_t     prev_val,
    input  logic       prev_valid,
    input  logic [2:0] prev_gt,
    input  pixel_t     next_val,
    input  logic       next_valid,
    output pixel_t     val,
    output logic       valid,
    output logic [2:0] gt
);

    pixel_t val_reg, val_next;
    logic   valid_reg, valid_next;

    // empty cells compare as +infinity
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            gt[c] = !valid_reg || (din[c] < val_reg[c]);
        end
    end

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.insert)
        begin
            valid_next = valid_reg | prev_valid;
            for (int c = 0; c < 3; c++)
            begin
                if (prev_gt[c])
                    val_next[c] = prev_val[c];
                else if (gt[c])
                    val_next[c] = din[c];
            end
        end
        else if (ctl.shift)
        begin
            valid_next = next_valid;
            val_next   = next_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule
